// ----- hw/rtl/pph_pkg.sv -----
package pph_pkg;

   localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] LANE_BASE = 64'h0123456789ABCDEF;
   localparam logic [63:0] INIT_K0   = 64'hDEADBEEFCAFEBABE;
   localparam logic [63:0] INIT_K1   = 64'h13198A2E03707344;
   localparam logic [63:0] INIT_K3   = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] INIT_K4   = 64'h94D049BB133111EB;
   localparam logic [63:0] PAD_BYTE  = 64'h80;
   localparam logic [6:0]  RED_A     = 7'd59;
   localparam logic [6:0]  RED_B     = 7'd83;

   localparam int          LANES     = 5;
   localparam int          CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP = 1'b1;

   localparam logic [8:0] PRIMES [64] = '{
      9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,  9'd23,
      9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,  9'd59,
      9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,  9'd97,
      9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131, 9'd137,
      9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173, 9'd179,
      9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223, 9'd227,
      9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263, 9'd269,
      9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311, 9'd313
   };

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_SEED_START,
      OP_WAIT_SEED,
      OP_SEED_SET,
      OP_SAVE,
      OP_ABSORB,
      OP_PAD,
      OP_TRIG,
      OP_PMUL,
      OP_PRED,
      OP_SQ_START,
      OP_PR_START,
      OP_WAIT_T,
      OP_MIX,
      OP_RESTORE
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] lane;
      logic [5:0] bit_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic mm_done;
      logic last;
      logic full;
   } dp_stat_type;

   // Tail of the reduction modulo 2^64-c of a 72-bit partly folded value.
   function automatic logic [63:0] fold_tail(input logic [71:0] s, input logic [6:0] c);
      logic [14:0] hc;
      logic [64:0] t;
      logic [63:0] r;
      logic [63:0] m;
      m  = 64'd0 - {57'd0, c};
      hc = s[71:64] * c;
      t  = {1'b0, s[63:0]} + {50'd0, hc};
      r  = t[64] ? (t[63:0] + {57'd0, c}) : t[63:0];
      if (r >= m) r = r - m;
      return r;
   endfunction

   // Reduce a 64x9 product modulo 2^64-c.
   function automatic logic [63:0] small_red(input logic [72:0] p, input logic [6:0] c);
      logic [15:0] hc;
      logic [71:0] s;
      hc = p[72:64] * c;
      s  = {8'd0, p[63:0]} + {56'd0, hc};
      return fold_tail(s, c);
   endfunction

   function automatic logic [63:0] swap64(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7-i) +: 8];
      return r;
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
      return (v >> n) | (v << (64 - n));
   endfunction

endpackage

// ----- hw/rtl/pph_if.sv -----
interface pph_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_bytes;
   logic [3:0]  byte_count;
   logic        last_item;
   modport source (output valid, message_bytes, byte_count, last_item, input ready);
   modport sink   (input valid, message_bytes, byte_count, last_item, output ready);
endinterface

interface pph_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_word;
   logic [1:0]  word_index;
   logic        last_word;
   modport source (output valid, hash_word, word_index, last_word, input ready);
   modport sink   (input valid, hash_word, word_index, last_word, output ready);
endinterface

// ----- hw/rtl/pph_modmul.sv -----
module pph_modmul import pph_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   input  logic        sel_b,
   output logic        done,
   output logic [63:0] result,
   output logic [63:0] raw_lo
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [63:0]  a_ff, b_ff, res_ff;
   logic         selb_ff;
   logic [127:0] acc_ff;
   logic [71:0]  s_ff;
   logic [6:0]   red_c;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_ext;
   logic [70:0]  hi_c;

   assign red_c  = selb_ff ? RED_B : RED_A;
   assign a_half = cnt_ff[0] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = cnt_ff[1] ? b_ff[63:32] : b_ff[31:0];
   assign pp     = a_half * b_half;
   assign hi_c   = acc_ff[127:64] * red_c;

   // Place the partial product by its half positions
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    pp_ext = {64'd0, pp};
         2'd3:    pp_ext = {pp, 64'd0};
         default: pp_ext = {32'd0, pp, 32'd0};
      endcase
   end

   // Advance the step counter
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Accumulate four partial products, fold once, then finish the reduction
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= op_a;
         b_ff    <= op_b;
         selb_ff <= sel_b;
         acc_ff  <= 128'd0;
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            acc_ff <= acc_ff + pp_ext;
         end else if (cnt_ff == 3'd4) begin
            s_ff <= {1'b0, hi_c} + {8'd0, acc_ff[63:0]};
         end else begin
            res_ff <= fold_tail(s_ff, red_c);
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;
   assign raw_lo = acc_ff[63:0];

endmodule

// ----- hw/rtl/pph_datapath.sv -----
module pph_datapath import pph_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic [63:0]          message_bytes,
   input  logic [3:0]           byte_count,
   input  logic                 last_item,
   output logic [63:0]          hash_word
);

   logic [63:0] seed_ff;
   logic        swap_ff;
   logic [63:0] lane_ff [LANES];
   logic [63:0] init_ff [LANES];
   logic [63:0] t_ff    [LANES];
   logic [63:0] derived [LANES];
   logic [63:0] mixed   [LANES];
   logic [63:0] pa_ff, pb_ff, trig_ff, sprod_ff;
   logic [72:0] proda_ff, prodb_ff;
   logic [63:0] msg_ff;
   logic [3:0]  cnt_ff;
   logic        last_ff;
   logic        full;
   logic [5:0]  pad_sh;
   logic [63:0] absorb_word;
   logic        mm_start, mm_done;
   logic [63:0] mm_a, mm_b, mm_res, mm_raw;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 64'd0;
         swap_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEED: seed_ff <= csr_wdata;
            CSR_SWAP: swap_ff <= csr_wdata[0];
            default:  ;
         endcase
      end
   end

   // Pad the final word: clear unused bytes, put the marker after the data
   assign full        = (cnt_ff >= 4'd8);
   assign pad_sh      = {cnt_ff[2:0], 3'd0};
   assign absorb_word = (!last_ff || full) ? msg_ff :
                        ((msg_ff & ((64'd1 << pad_sh) - 64'd1)) | (PAD_BYTE << pad_sh));

   // Initial lanes, three of them mixed with the seed, a zero lane replaced by three
   always_comb begin
      derived[0] = LANE_BASE + INIT_K0;
      derived[1] = (LANE_BASE ^ INIT_K1) ^ seed_ff;
      derived[2] = LANE_BASE + GOLDEN;
      derived[3] = (LANE_BASE ^ INIT_K3) ^ sprod_ff;
      derived[4] = (LANE_BASE + INIT_K4) ^ {seed_ff[31:0], seed_ff[63:32]};
      for (int i = 0; i < LANES; i++)
         if (derived[i] == 64'd0) derived[i] = 64'd3;
   end

   // Diffusion layer
   always_comb begin
      mixed[0] = t_ff[0] ^ rotr(t_ff[1], 17);
      mixed[1] = t_ff[1] ^ rotr(t_ff[2], 11);
      mixed[2] = t_ff[2] ^ rotr(t_ff[3], 19);
      mixed[3] = t_ff[3] ^ rotr(t_ff[4], 13);
      mixed[4] = t_ff[4] ^ rotr(t_ff[0], 23);
   end

   // Select multiplier operands
   always_comb begin
      mm_start = 1'b0;
      mm_a     = lane_ff[cmd.lane];
      mm_b     = lane_ff[cmd.lane];
      case (cmd.op)
         OP_SEED_START: begin
            mm_start = 1'b1;
            mm_a     = seed_ff;
            mm_b     = GOLDEN;
         end
         OP_SQ_START: mm_start = 1'b1;
         OP_PR_START: begin
            mm_start = 1'b1;
            mm_a     = t_ff[cmd.lane];
            mm_b     = cmd.lane[0] ? pb_ff : pa_ff;
         end
         default: ;
      endcase
   end

   pph_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_start),
      .op_a   (mm_a),
      .op_b   (mm_b),
      .sel_b  (cmd.lane[0]),
      .done   (mm_done),
      .result (mm_res),
      .raw_lo (mm_raw)
   );

   // Execute the command
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            msg_ff  <= message_bytes;
            cnt_ff  <= byte_count;
            last_ff <= last_item;
         end
         OP_WAIT_SEED: if (mm_done) sprod_ff <= mm_raw;
         OP_SEED_SET:  lane_ff <= derived;
         OP_SAVE:      init_ff <= lane_ff;
         OP_ABSORB:    lane_ff[0] <= lane_ff[0] ^ (swap_ff ? swap64(absorb_word) : absorb_word);
         OP_PAD:       lane_ff[0] <= lane_ff[0] ^ (swap_ff ? swap64(PAD_BYTE) : PAD_BYTE);
         OP_TRIG: begin
            trig_ff <= lane_ff[0] ^ lane_ff[2] ^ lane_ff[4] ^ GOLDEN;
            pa_ff   <= 64'd1;
            pb_ff   <= 64'd1;
         end
         OP_PMUL: begin
            proda_ff <= pa_ff * PRIMES[cmd.bit_idx];
            prodb_ff <= pb_ff * PRIMES[cmd.bit_idx];
         end
         OP_PRED: begin
            if (trig_ff[cmd.bit_idx]) begin
               pa_ff <= small_red(proda_ff, RED_A);
               pb_ff <= small_red(prodb_ff, RED_B);
            end
         end
         OP_WAIT_T:  if (mm_done) t_ff[cmd.lane] <= mm_res;
         OP_MIX:     lane_ff <= mixed;
         OP_RESTORE: lane_ff <= init_ff;
         default: ;
      endcase
   end

   assign stat.mm_done = mm_done;
   assign stat.last    = last_ff;
   assign stat.full    = full;
   assign hash_word    = swap_ff ? swap64(lane_ff[0]) : lane_ff[0];

endmodule

// ----- hw/rtl/pph_ctrl.sv -----
module pph_ctrl import pph_pkg::*; #(
   parameter int FINAL_ROUNDS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           word_index,
   output logic                 last_word,
   output dp_cmd_type           cmd,
   input  dp_stat_type          stat
);

   localparam int RW = $clog2(FINAL_ROUNDS + 2);

   typedef enum logic [17:0] {
      ST_INIT      = 18'h00001,
      ST_SEED_WAIT = 18'h00002,
      ST_SEED_SET  = 18'h00004,
      ST_SAVE      = 18'h00008,
      ST_IDLE      = 18'h00010,
      ST_ABSORB    = 18'h00020,
      ST_PAD       = 18'h00040,
      ST_FINAL     = 18'h00080,
      ST_OUT       = 18'h00100,
      ST_RESTORE   = 18'h00200,
      ST_TRIG      = 18'h00400,
      ST_PMUL      = 18'h00800,
      ST_PRED      = 18'h01000,
      ST_SQ_START  = 18'h02000,
      ST_SQ_WAIT   = 18'h04000,
      ST_PR_START  = 18'h08000,
      ST_PR_WAIT   = 18'h10000,
      ST_MIX       = 18'h20000
   } state_type;

   typedef enum logic [2:0] {
      MODE_DERIVE,
      MODE_ABSORB,
      MODE_PAD,
      MODE_FINAL,
      MODE_OUT
   } mode_type;

   state_type     state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic          pend_ff, pend_in;
   logic [5:0]    bit_ff, bit_in;
   logic [2:0]    lane_ff, lane_in;
   logic [RW-1:0] round_ff, round_in;
   logic [1:0]    word_ff, word_in;
   logic          seed_wr;

   assign seed_wr   = csr_we && (csr_index == CSR_SEED);
   assign req_ready = (state_ff == ST_IDLE) && !pend_ff;
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      bit_in   = bit_ff;
      lane_in  = lane_ff;
      round_in = round_ff;
      word_in  = word_ff;
      pend_in  = pend_ff;
      cmd.op      = OP_NOP;
      cmd.lane    = lane_ff;
      cmd.bit_idx = bit_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.op   = OP_SEED_START;
            pend_in  = 1'b0;
            state_in = ST_SEED_WAIT;
         end
         ST_SEED_WAIT: begin
            cmd.op = OP_WAIT_SEED;
            if (stat.mm_done) state_in = ST_SEED_SET;
         end
         ST_SEED_SET: begin
            cmd.op   = OP_SEED_SET;
            mode_in  = MODE_DERIVE;
            state_in = ST_TRIG;
         end
         ST_SAVE: begin
            cmd.op   = OP_SAVE;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pend_ff) begin
               state_in = ST_INIT;
            end else if (req_valid) begin
               cmd.op   = OP_LOAD;
               round_in = '0;
               word_in  = 2'd0;
               state_in = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            cmd.op   = OP_ABSORB;
            mode_in  = MODE_ABSORB;
            state_in = ST_TRIG;
         end
         ST_PAD: begin
            cmd.op   = OP_PAD;
            mode_in  = MODE_PAD;
            state_in = ST_TRIG;
         end
         ST_FINAL: begin
            if (round_ff == RW'(FINAL_ROUNDS)) begin
               state_in = ST_OUT;
            end else begin
               round_in = round_ff + 1'b1;
               mode_in  = MODE_FINAL;
               state_in = ST_TRIG;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (word_ff == 2'd3) begin
                  state_in = ST_RESTORE;
               end else begin
                  word_in  = word_ff + 2'd1;
                  mode_in  = MODE_OUT;
                  state_in = ST_TRIG;
               end
            end
         end
         ST_RESTORE: begin
            cmd.op   = OP_RESTORE;
            state_in = ST_IDLE;
         end
         ST_TRIG: begin
            cmd.op   = OP_TRIG;
            bit_in   = 6'd0;
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.op   = OP_PMUL;
            state_in = ST_PRED;
         end
         ST_PRED: begin
            cmd.op = OP_PRED;
            if (bit_ff == 6'd63) begin
               lane_in  = 3'd0;
               state_in = ST_SQ_START;
            end else begin
               bit_in   = bit_ff + 6'd1;
               state_in = ST_PMUL;
            end
         end
         ST_SQ_START: begin
            cmd.op   = OP_SQ_START;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            cmd.op = OP_WAIT_T;
            if (stat.mm_done) state_in = ST_PR_START;
         end
         ST_PR_START: begin
            cmd.op   = OP_PR_START;
            state_in = ST_PR_WAIT;
         end
         ST_PR_WAIT: begin
            cmd.op = OP_WAIT_T;
            if (stat.mm_done) begin
               if (lane_ff == 3'(LANES - 1)) begin
                  state_in = ST_MIX;
               end else begin
                  lane_in  = lane_ff + 3'd1;
                  state_in = ST_SQ_START;
               end
            end
         end
         ST_MIX: begin
            cmd.op = OP_MIX;
            case (mode_ff)
               MODE_DERIVE: state_in = ST_SAVE;
               MODE_ABSORB: begin
                  if (!stat.last)     state_in = ST_IDLE;
                  else if (stat.full) state_in = ST_PAD;
                  else                state_in = ST_FINAL;
               end
               MODE_OUT: state_in = ST_OUT;
               default:  state_in = ST_FINAL;
            endcase
         end
         default: state_in = ST_INIT;
      endcase
      // A seed write sets a pending flag; from idle the block then derives the lanes anew
      if (seed_wr) pend_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         mode_ff  <= MODE_DERIVE;
         pend_ff  <= 1'b0;
         bit_ff   <= 6'd0;
         lane_ff  <= 3'd0;
         round_ff <= '0;
         word_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         bit_ff   <= bit_in;
         lane_ff  <= lane_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

   assign word_index = word_ff;
   assign last_word  = (word_ff == 2'd3);

endmodule

// ----- hw/rtl/prime_product_sponge_hash.sv -----
// Seeded 256-bit sponge hash over a byte stream, five 64-bit lanes. Each req transfer
// carries up to eight bytes; a transfer with last_item set yields four rsp transfers,
// digest words 0..3. Every permutation walks over the 64 trigger bits, both moduli at
// once, then runs ten modular multiplies in the one shared 32x32-per-cycle multiplier.
// A non-last item takes one permutation; a last item takes 3 + FINAL_ROUNDS + 1
// permutations (one more when its byte_count is eight or more) and the output
// handshakes. After reset and after each CSR_SEED write the block spends one
// permutation deriving the initial lanes and holds req.ready low until done.
// Write configuration only while idle.
module prime_product_sponge_hash import pph_pkg::*; #(
   parameter int FINAL_ROUNDS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata,
   pph_req_if.sink              req,
   pph_rsp_if.source            rsp
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pph_ctrl #(
      .FINAL_ROUNDS (FINAL_ROUNDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .word_index (rsp.word_index),
      .last_word  (rsp.last_word),
      .cmd        (cmd),
      .stat       (stat)
   );

   pph_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .stat          (stat),
      .message_bytes (req.message_bytes),
      .byte_count    (req.byte_count),
      .last_item     (req.last_item),
      .hash_word     (rsp.hash_word)
   );

endmodule

// ----- bench/prime_product_sponge_hash_test.sv -----
module prime_product_sponge_hash_test;
   import pph_pkg::*;

   localparam int          FINAL_PERMS = 2;
   localparam int          SETTLE      = 400;
   localparam int          CYCLE_LIMIT = 3000000;
   localparam logic [63:0] PRIME_A     = 64'hFFFFFFFFFFFFFFC5;
   localparam logic [63:0] PRIME_B     = 64'hFFFFFFFFFFFFFFAD;

   typedef struct {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   // Digest predictor and the queue of words still owed by the block
   class DigestScoreboard;
      logic [63:0]     seed;
      logic            swap;
      logic [63:0]     lanes [5];
      logic [63:0]     start_lanes [5];
      digest_word_type owed [$];

      function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
         logic [127:0] p;
         p = {64'd0, x} * {64'd0, y};
         p = p % {64'd0, m};
         return p[63:0];
      endfunction

      function automatic logic [63:0] ror(logic [63:0] v, int n);
         return (v >> n) | (v << (64 - n));
      endfunction

      function automatic logic [63:0] reorder(logic [63:0] v);
         logic [63:0] r;
         r = v;
         if (swap)
            for (int i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7-i) +: 8];
         return r;
      endfunction

      function void scramble(ref logic [63:0] s [5]);
         logic [63:0] trig, pa, pb;
         logic [63:0] t [5];
         trig = s[0] ^ s[2] ^ s[4] ^ GOLDEN;
         pa = 1;
         pb = 1;
         for (int i = 0; i < 64; i++) begin
            if (trig[i]) begin
               pa = mulmod(pa, {55'd0, PRIMES[i]}, PRIME_A);
               pb = mulmod(pb, {55'd0, PRIMES[i]}, PRIME_B);
            end
         end
         for (int i = 0; i < 5; i++) begin
            if (i % 2 == 0) t[i] = mulmod(mulmod(s[i], s[i], PRIME_A), pa, PRIME_A);
            else t[i] = mulmod(mulmod(s[i], s[i], PRIME_B), pb, PRIME_B);
         end
         s[0] = t[0] ^ ror(t[1], 17);
         s[1] = t[1] ^ ror(t[2], 11);
         s[2] = t[2] ^ ror(t[3], 19);
         s[3] = t[3] ^ ror(t[4], 13);
         s[4] = t[4] ^ ror(t[0], 23);
      endfunction

      function void reseed(logic [63:0] v);
         seed = v;
         start_lanes[0] = LANE_BASE + INIT_K0;
         start_lanes[1] = (LANE_BASE ^ INIT_K1) ^ v;
         start_lanes[2] = LANE_BASE + GOLDEN;
         start_lanes[3] = (LANE_BASE ^ INIT_K3) ^ (v * GOLDEN);
         start_lanes[4] = (LANE_BASE + INIT_K4) ^ {v[31:0], v[63:32]};
         // a lane that mixes to zero is forced to three
         for (int i = 0; i < 5; i++) if (start_lanes[i] == 0) start_lanes[i] = 3;
         scramble(start_lanes);
         lanes = start_lanes;
      endfunction

      function new();
         swap = 0;
         reseed(0);
      endfunction

      function void absorb(logic [63:0] w);
         lanes[0] ^= reorder(w);
         scramble(lanes);
      endfunction

      // Note an accepted request transfer and queue any digest words it yields
      function void note(logic [63:0] msg, logic [3:0] cnt, logic fin);
         digest_word_type d;
         logic [63:0] mask;
         if (!fin) begin
            absorb(msg);
            return;
         end
         if (cnt >= 8) begin
            absorb(msg);
            absorb(PAD_BYTE);
         end else begin
            mask = (64'd1 << (cnt * 8)) - 1;
            absorb((msg & mask) | (PAD_BYTE << (cnt * 8)));
         end
         for (int r = 0; r < FINAL_PERMS; r++) scramble(lanes);
         for (int k = 0; k < 4; k++) begin
            if (k > 0) scramble(lanes);
            d.word  = reorder(lanes[0]);
            d.index = k[1:0];
            d.last  = (k == 3);
            owed.push_back(d);
         end
         lanes = start_lanes;
      endfunction

      // Check a response transfer against the oldest owed word
      function string check(logic [63:0] w, logic [1:0] idx, logic lw);
         digest_word_type d;
         string msg;
         if (owed.size() == 0) return $sformatf("unexpected digest word %h", w);
         d = owed.pop_front();
         msg = "";
         if (w !== d.word) msg = {msg, $sformatf(" hash_word %h want %h", w, d.word)};
         if (idx !== d.index) msg = {msg, $sformatf(" word_index %0d want %0d", idx, d.index)};
         if (lw !== d.last) msg = {msg, $sformatf(" last_word %b want %b", lw, d.last)};
         return msg;
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_wdata;
   int                   errors;
   int                   cycles;
   DigestScoreboard      sb;

   pph_req_if req ();
   pph_rsp_if rsp ();

   prime_product_sponge_hash dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req.sink),
      .rsp       (rsp.source)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   task automatic report(string msg);
      $display("mismatch at cycle %0d:%s", cycles, msg);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   // Drop the deadline hammer
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Stall the response side at random, with long calm stretches
   int calm;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         calm <= 0;
      end else if (calm > 0) begin
         rsp.ready <= 1'b1;
         calm <= calm - 1;
      end else if ($urandom_range(0, 49) == 0) begin
         calm <= $urandom_range(20, 200);
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= (pick_gap() == 0);
      end
   end

   // Check every response transfer
   always @(posedge clock) begin
      string msg;
      if (!reset && rsp.valid && rsp.ready) begin
         msg = sb.check(rsp.hash_word, rsp.word_index, rsp.last_word);
         if (msg != "") report(msg);
      end
   end

   task automatic send(logic [63:0] msg, logic [3:0] cnt, logic fin);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.message_bytes <= msg;
      req.byte_count    <= cnt;
      req.last_item     <= fin;
      do @(posedge clock); while (!req.ready);
      sb.note(msg, cnt, fin);
   endtask

   // Hold until every owed word is back and the block has settled
   task automatic drain();
      req.valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write one register, then drop the write enable before returning
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [63:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_SEED) sb.reseed(v);
      else sb.swap = v[0];
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_messages(int n);
      int body;
      int r;
      logic [3:0] cnt;
      while (n > 0) begin
         body = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
         for (int i = 0; i < body; i++) begin
            send(rand64(), 4'($urandom_range(0, 15)), 1'b0);
            n--;
         end
         r = $urandom_range(0, 9);
         cnt = (r == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
         send(rand64(), cnt, 1'b1);
         n--;
      end
   endtask

   initial begin
      sb        = new();
      errors    = 0;
      cycles    = 0;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_SEED;
      csr_wdata = 64'd0;
      req.valid         = 1'b0;
      req.message_bytes = 64'd0;
      req.byte_count    = 4'd0;
      req.last_item     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, every tail length, oversize counts, junk above count
      send(64'd0, 4'd0, 1'b1);
      for (int c = 0; c <= 8; c++) send(64'hFFFFFFFFFFFFFFFF, 4'(c), 1'b1);
      send(64'h0123456789ABCDEF, 4'd9, 1'b1);
      send(64'hFEDCBA9876543210, 4'd15, 1'b1);
      send(64'hFFFFFFFFFFFFFFFF, 4'd3, 1'b0);
      send(64'd0, 4'd15, 1'b0);
      send(64'hA5A5A5A5A5A5A5A5, 4'd5, 1'b1);
      drain();

      // Extreme seed, swapped order
      csr_write(CSR_SEED, 64'hFFFFFFFFFFFFFFFF);
      csr_write(CSR_SWAP, 64'd1);
      send(64'h1122334455667788, 4'd8, 1'b0);
      send(64'h99AABBCCDDEEFF00, 4'd4, 1'b1);
      random_messages(80);
      drain();

      // Seed that zeroes lane one before permutation
      csr_write(CSR_SEED, LANE_BASE ^ INIT_K1);
      csr_write(CSR_SWAP, 64'd0);
      random_messages(60);
      // Flip byte order in the middle of a message
      send(rand64(), 4'd8, 1'b0);
      drain();
      csr_write(CSR_SWAP, 64'd1);
      send(rand64(), 4'd2, 1'b1);
      drain();

      // Seed write discards a message in progress
      send(rand64(), 4'd8, 1'b0);
      send(rand64(), 4'd8, 1'b0);
      drain();
      csr_write(CSR_SEED, rand64());
      random_messages(100);
      drain();

      csr_write(CSR_SEED, 64'd0);
      csr_write(CSR_SWAP, 64'd0);
      random_messages(80);
      drain();
      csr_write(CSR_SEED, rand64());
      csr_write(CSR_SWAP, 64'($urandom_range(0, 1)));
      random_messages(80);
      drain();

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/pph_pkg.sv
hw/rtl/pph_if.sv
hw/rtl/pph_modmul.sv
hw/rtl/pph_datapath.sv
hw/rtl/pph_ctrl.sv
hw/rtl/prime_product_sponge_hash.sv
bench/prime_product_sponge_hash_test.sv
